FILE: rtl/first_best_fit_block_allocator_defines.svh
// Assertion macros shared by the allocator modules.
`ifndef FIRST_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk and off during reset.
`define FBBA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and off during reset.
`define FBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fbba_pkg.sv
// Shared types, codes and sizing constants of the block allocator.
package fbba_pkg;

	// Table sizing.
	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int PADDR_W    = 3;

	localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

	// Item opcodes.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_LOADED   = 3'd0,
		ST_GRANTED  = 3'd1,
		ST_NOFIT    = 3'd2,
		ST_REJECTED = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	// Configuration register index, taken from paddr[2].
	typedef enum logic {
		REG_FIT_MODE    = 1'b0,
		REG_BLOCK_COUNT = 1'b1
	} reg_idx_t;

	// Input item.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  slot;
		logic [7:0]  tag;
		logic [15:0] size;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] granted_slot;
		logic [7:0] granted_tag;
	} rsp_t;

	// Configuration register contents.
	typedef struct packed {
		logic       fit_mode;
		logic [4:0] block_count;
	} cfg_t;

	// One table entry as stored in the RAM.
	typedef struct packed {
		logic [SIZE_BITS-1:0] size;
		logic [7:0]           tag;
	} blk_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic scan_en;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/first_best_fit_block_allocator.sv
// Top level of the first-fit / best-fit partition allocator.
//
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   fbba_pkg::req_t (opcode, slot, tag, size)
// rsp       out        rsp_valid / rsp_stall   fbba_pkg::rsp_t (status, granted_slot, granted_tag)
// apb       in         psel / penable / pready fit_mode at 0x0, block_count at 0x4
//
// Loads, clears, rejected items and unknown opcodes skip the scan and go from decode to result.
// An allocate with a nonzero id scans min(block_count, NUM_BLOCKS) slots: the table RAM
// has one read port, so the scan reads one slot per cycle, then waits for the registered
// read data and for the reads to drain before the result is written.
// Reset frees all slots at once through per-slot ownership flops; there is no clearing pass.
// A stalled result holds in the output register; the next item is accepted meanwhile
// and waits for that register before its own result is written.
module first_best_fit_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  fbba_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output fbba_pkg::rsp_t              rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbba_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import fbba_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Configuration registers.
	fbba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	fbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table, scan and result path.
	fbba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/fbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/fbba_cfg.sv
// APB-style configuration registers of the block allocator.
module fbba_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbba_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output fbba_pkg::cfg_t              cfg
);
	import fbba_pkg::*;

	logic     fit_mode_q;
	logic [4:0] block_count_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	// Register writes complete on the access cycle of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= 1'b0;
			block_count_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_FIT_MODE:    fit_mode_q    <= pwdata[0];
				REG_BLOCK_COUNT: block_count_q <= pwdata[4:0];
				default:         ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (idx)
			REG_FIT_MODE:    prdata = {31'b0, fit_mode_q};
			REG_BLOCK_COUNT: prdata = {27'b0, block_count_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.fit_mode    = fit_mode_q;
	assign cfg.block_count = block_count_q;

endmodule

FILE: rtl/fbba_ctrl.sv
// Controller state machine that sequences load, scan and result steps.
module fbba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  fbba_pkg::dp_sts_t  sts,
	output fbba_pkg::dp_cmd_t  cmd
);
	import fbba_pkg::*;

	`include "first_best_fit_block_allocator_defines.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_RESULT
	} state_t;

	state_t state_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= sts.need_scan ? S_SCAN : S_RESULT;
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands follow the state; an item is taken only when idle.
	assign req_stall   = (state_q != S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && req_valid;
	assign cmd.scan_en = (state_q == S_SCAN);
	assign cmd.finish  = (state_q == S_RESULT) && sts.out_free;

	`FBBA_ASSERT_NEXT(a_accept_decode, req_valid && !req_stall, state_q == S_DECODE, "accepted item did not move to decode")
	`FBBA_ASSERT_NEXT(a_finish_idle, cmd.finish, state_q == S_IDLE, "controller did not return to idle after a result")
	`FBBA_ASSERT_NEXT(a_noscan_result, (state_q == S_DECODE) && !sts.need_scan, state_q == S_RESULT, "item without a scan did not go to result")

endmodule

FILE: rtl/fbba_dp.sv
// Datapath: item register, partition table, fit scan and result register.
module fbba_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  fbba_pkg::req_t     req,
	input  fbba_pkg::cfg_t     cfg,
	input  fbba_pkg::dp_cmd_t  cmd,
	output fbba_pkg::dp_sts_t  sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output fbba_pkg::rsp_t     rsp
);
	import fbba_pkg::*;

	`include "first_best_fit_block_allocator_defines.svh"

	req_t                 item_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     issue_cnt_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [7:0]           best_tag_q;
	logic [NUM_BLOCKS-1:0] used_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 issue_en;
	logic                 fits;
	logic                 hit;
	logic                 slot_oor;
	logic                 load_ok;
	logic                 grant;
	logic [IDX_W-1:0]     load_idx;
	logic [SIZE_BITS-1:0] load_size;
	blk_entry_t           wr_entry;
	blk_entry_t           rd_entry;
	logic [$bits(blk_entry_t)-1:0] ram_rdata;
	rsp_t                 result;

	// Size and tag table; the scan reads every entry below the block count, loaded or not.
	fbba_ram #(
		.WIDTH ($bits(blk_entry_t)),
		.DEPTH (NUM_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (cmd.finish && load_ok),
		.waddr (load_idx),
		.wdata (wr_entry),
		.raddr (issue_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_entry = blk_entry_t'(ram_rdata);

	// Load decode: range check and clamp of the stored size.
	assign slot_oor  = 32'(item_q.slot) >= 32'(NUM_BLOCKS);
	assign load_ok   = (item_q.opcode == OP_LOAD) && !slot_oor;
	assign load_idx  = IDX_W'(item_q.slot);
	assign load_size = (32'(item_q.size) > 32'(SIZE_MAX)) ? SIZE_MAX
		: SIZE_BITS'(item_q.size);
	assign wr_entry.size = load_size;
	assign wr_entry.tag  = item_q.tag;

	// Scan: one read issued per cycle, compared in the next cycle.
	assign issue_en = cmd.scan_en && (issue_cnt_q < limit_q);
	assign fits     = rd_vld_s1 && !used_q[rd_idx_s1]
		&& (32'(rd_entry.size) >= 32'(item_q.size));
	assign hit      = fits && (!found_q || (cfg.fit_mode && (rd_entry.size < best_size_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.capture) begin
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_en;
			if (issue_en) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// Item capture and best-candidate payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q  <= req;
			limit_q <= (32'(cfg.block_count) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
				: CNT_W'(cfg.block_count);
		end
		rd_idx_s1 <= issue_cnt_q[IDX_W-1:0];
		if (hit) begin
			best_idx_q  <= rd_idx_s1;
			best_size_q <= rd_entry.size;
			best_tag_q  <= rd_entry.tag;
		end
	end

	// Result of the item in hand.
	assign grant = (item_q.opcode == OP_ALLOC) && (item_q.tag != 8'd0) && found_q;

	always_comb begin
		result = '0;
		case (item_q.opcode)
			OP_LOAD: begin
				result.status = slot_oor ? ST_REJECTED : ST_LOADED;
			end
			OP_ALLOC: begin
				if (item_q.tag == 8'd0) begin
					result.status = ST_REJECTED;
				end else if (found_q) begin
					result.status       = ST_GRANTED;
					result.granted_slot = 4'(best_idx_q);
					result.granted_tag  = best_tag_q;
				end else begin
					result.status = ST_NOFIT;
				end
			end
			OP_CLEAR: begin
				result.status = ST_CLEARED;
			end
			default: begin
				result.status = ST_REJECTED;
			end
		endcase
	end

	// Ownership bits: set on a grant, cleared by a load or a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.finish) begin
			if (item_q.opcode == OP_CLEAR) begin
				used_q <= '0;
			end else if (load_ok) begin
				used_q[load_idx] <= 1'b0;
			end else if (grant) begin
				used_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// Output register holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;
	assign sts.need_scan = (item_q.opcode == OP_ALLOC) && (item_q.tag != 8'd0);
	assign sts.scan_done = (issue_cnt_q == limit_q) && !rd_vld_s1;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	`FBBA_ASSERT_IMPLIES(a_no_overwrite, cmd.finish, !rsp_valid_q || !rsp_stall, "result register overwritten before its transfer")
	`FBBA_ASSERT_IMPLIES(a_scan_drained, cmd.finish, !rd_vld_s1, "result produced with a table read still in flight")
	`FBBA_ASSERT_NEXT(a_grant_owned, cmd.finish && grant, used_q[$past(best_idx_q)], "granted slot not marked as owned")

endmodule
